[rtl/core/ibs_pkg.sv]
// Shared types, constants and helpers for the bilinear image sampler.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package ibs_pkg;

	// Image store geometry
	localparam int MAX_COLS    = 256;
	localparam int MAX_ROWS    = 256;
	localparam int COL_BITS    = $clog2(MAX_COLS);
	localparam int ROW_BITS    = $clog2(MAX_ROWS);
	localparam int DIM_BITS    = 9;

	// Number formats
	localparam int FRAC_BITS   = 8;
	localparam int PIXEL_BITS  = 16;
	localparam int SAMPLE_BITS = 17;
	localparam int COORD_BITS  = COL_BITS + FRAC_BITS;

	// Four banks, split by row parity (msb) and column parity (lsb)
	localparam int NUM_BANKS   = 4;
	localparam int BANK_SEL_W  = 2;
	localparam int BANK_AW     = (ROW_BITS - 1) + (COL_BITS - 1);
	localparam int BANK_DEPTH  = 1 << BANK_AW;

	// Blend datapath widths
	localparam int LERP_BITS   = PIXEL_BITS + FRAC_BITS;
	localparam int ACC_BITS    = PIXEL_BITS + 2 * FRAC_BITS;

	typedef enum logic {
		ACT_WRITE  = 1'b0,
		ACT_SAMPLE = 1'b1
	} ibs_action_t;

	typedef enum logic {
		REG_IMAGE_COLS = 1'b0,
		REG_IMAGE_ROWS = 1'b1
	} ibs_reg_t;

	// Per-sample control carried from address generation to the blend
	typedef struct packed {
		logic                 x0_par;
		logic                 x1_par;
		logic                 y0_par;
		logic                 y1_par;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fy;
		logic                 clamped;
	} ibs_sel_t;

	// Dimension register to dimension in use: zero reads as one, large saturates
	function automatic logic [DIM_BITS-1:0] dim_in_use(
		input logic [DIM_BITS-1:0] reg_val,
		input logic [DIM_BITS-1:0] limit
	);
		logic [DIM_BITS-1:0] res;
		res = reg_val;
		if (reg_val == '0) begin
			res = DIM_BITS'(1);
		end else if (reg_val > limit) begin
			res = limit;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

[rtl/core/ibs_bank_ram.sv]
// One pixel bank: synchronous RAM, one write port, one registered read port.
// Depends on ibs_pkg for bank depth and pixel width.
`default_nettype none

module ibs_bank_ram (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [ibs_pkg::BANK_AW-1:0]    wr_addr,
	input  wire logic [ibs_pkg::PIXEL_BITS-1:0] wr_data,
	input  wire logic                          re,
	input  wire logic [ibs_pkg::BANK_AW-1:0]    rd_addr,
	output      logic [ibs_pkg::PIXEL_BITS-1:0] rd_data
);
	import ibs_pkg::*;

	logic [PIXEL_BITS-1:0] mem [BANK_DEPTH];
	logic [PIXEL_BITS-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[rtl/core/ibs_addr.sv]
// Coordinate clamp, neighbour selection and bank address generation.
// Depends on ibs_pkg for widths and the ibs_sel_t control struct.
`default_nettype none

module ibs_addr (
	input  wire logic                                               clk,
	input  wire logic                                               arst_n,
	input  wire logic                                               sample_req,
	input  wire logic [ibs_pkg::SAMPLE_BITS-1:0]                    sample_x,
	input  wire logic [ibs_pkg::SAMPLE_BITS-1:0]                    sample_y,
	input  wire logic [ibs_pkg::DIM_BITS-1:0]                       cols_use,
	input  wire logic [ibs_pkg::DIM_BITS-1:0]                       rows_use,
	output      logic [ibs_pkg::NUM_BANKS-1:0][ibs_pkg::BANK_AW-1:0] rd_addr,
	output      ibs_pkg::ibs_sel_t                                  sel
);
	import ibs_pkg::*;

	localparam int CMP_W = SAMPLE_BITS + 2;

	logic signed [CMP_W-1:0] sx_ext, sy_ext;
	logic signed [CMP_W-1:0] x_lim, y_lim, x_top, y_top, neg_one;
	logic                    x_out, y_out;
	logic [COORD_BITS-1:0]   xe, ye;
	logic [COL_BITS-1:0]     x0, x1;
	logic [ROW_BITS-1:0]     y0, y1;
	logic [DIM_BITS-1:0]     x0_inc, y0_inc;
	logic [COL_BITS-1:0]     col_for [2];
	logic [ROW_BITS-1:0]     row_for [2];

	// Range check and clamp into [0, (n-1) << F]
	always_comb begin
		sx_ext  = CMP_W'($signed(sample_x));
		sy_ext  = CMP_W'($signed(sample_y));
		neg_one = -$signed(CMP_W'(1 << FRAC_BITS));
		x_lim   = $signed({{(CMP_W - DIM_BITS - FRAC_BITS){1'b0}}, cols_use, {FRAC_BITS{1'b0}}});
		y_lim   = $signed({{(CMP_W - DIM_BITS - FRAC_BITS){1'b0}}, rows_use, {FRAC_BITS{1'b0}}});
		x_top   = x_lim - $signed(CMP_W'(1 << FRAC_BITS));
		y_top   = y_lim - $signed(CMP_W'(1 << FRAC_BITS));
		x_out   = (sx_ext <= neg_one) || (sx_ext >= x_lim);
		y_out   = (sy_ext <= neg_one) || (sy_ext >= y_lim);

		if (sx_ext < 0) begin
			xe = '0;
		end else if (sx_ext > x_top) begin
			xe = x_top[COORD_BITS-1:0];
		end else begin
			xe = sx_ext[COORD_BITS-1:0];
		end
		if (sy_ext < 0) begin
			ye = '0;
		end else if (sy_ext > y_top) begin
			ye = y_top[COORD_BITS-1:0];
		end else begin
			ye = sy_ext[COORD_BITS-1:0];
		end
	end

	// Floor and ceiling neighbours, ceiling held at the last column or row
	always_comb begin
		x0     = xe[COORD_BITS-1:FRAC_BITS];
		y0     = ye[ROW_BITS+FRAC_BITS-1:FRAC_BITS];
		x0_inc = DIM_BITS'(x0) + DIM_BITS'(1);
		y0_inc = DIM_BITS'(y0) + DIM_BITS'(1);
		x1     = (x0_inc < cols_use) ? x0_inc[COL_BITS-1:0] : x0;
		y1     = (y0_inc < rows_use) ? y0_inc[ROW_BITS-1:0] : y0;
	end

	// Per parity, pick whichever neighbour lives in that bank column/row
	always_comb begin
		for (int p = 0; p < 2; p++) begin
			col_for[p[0]] = (x0[0] == p[0]) ? x0 : x1;
			row_for[p[0]] = (y0[0] == p[0]) ? y0 : y1;
		end
		for (int b = 0; b < NUM_BANKS; b++) begin
			rd_addr[b[1:0]] = {row_for[b[1]][ROW_BITS-1:1], col_for[b[0]][COL_BITS-1:1]};
		end
	end

	always_comb begin
		sel.x0_par  = x0[0];
		sel.x1_par  = x1[0];
		sel.y0_par  = y0[0];
		sel.y1_par  = y1[0];
		sel.fx      = xe[FRAC_BITS-1:0];
		sel.fy      = ye[FRAC_BITS-1:0];
		sel.clamped = x_out || y_out;
	end

`ifndef SYNTH
	// Neighbours stay inside the image in use
	ap_x_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		sample_req |-> (DIM_BITS'(x1) < cols_use) && (DIM_BITS'(x0) <= DIM_BITS'(x1)))
		else $error("column neighbour outside image");
	ap_y_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		sample_req |-> (DIM_BITS'(y1) < rows_use) && (DIM_BITS'(y0) <= DIM_BITS'(y1)))
		else $error("row neighbour outside image");
	// A collapsed pair only happens on the last column
	ap_x_collapse: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_req && (x1 == x0)) |-> (x0_inc >= cols_use))
		else $error("column pair collapsed away from the edge");
`endif

endmodule

`default_nettype wire

[rtl/core/ibs_blend.sv]
// Two-stage bilinear blend: horizontal lerps, then vertical lerp and rounding.
// Depends on ibs_pkg for widths and the ibs_sel_t control struct.
`default_nettype none

module ibs_blend (
	input  wire logic                                                  clk,
	input  wire logic                                                  arst_n,
	input  wire logic                                                  valid_s1,
	input  wire ibs_pkg::ibs_sel_t                                     sel_s1,
	input  wire logic [ibs_pkg::NUM_BANKS-1:0][ibs_pkg::PIXEL_BITS-1:0] bank_data,
	output      logic                                                  done,
	output      logic [ibs_pkg::PIXEL_BITS-1:0]                         sample_value,
	output      logic                                                  was_clamped
);
	import ibs_pkg::*;

	localparam int HM_W = PIXEL_BITS + FRAC_BITS + 2;
	localparam int VM_W = ACC_BITS + 2;

	logic [PIXEL_BITS-1:0]        p00, p01, p10, p11;
	logic signed [PIXEL_BITS:0]   d_top, d_bot;
	logic signed [FRAC_BITS:0]    fx_s;
	logic signed [HM_W-1:0]       h_top, h_bot;

	logic                         valid_s2;
	logic [LERP_BITS-1:0]         h0_s2, h1_s2;
	logic [FRAC_BITS-1:0]         fy_s2;
	logic                         clamped_s2;

	logic signed [LERP_BITS:0]    d_v;
	logic signed [FRAC_BITS:0]    fy_s;
	logic signed [VM_W-1:0]       acc;

	logic                         done_q;
	logic [PIXEL_BITS-1:0]        value_q;
	logic                         clamped_q;

	// Stage 1: route banks to neighbours, one lerp per row
	always_comb begin
		p00   = bank_data[{sel_s1.y0_par, sel_s1.x0_par}];
		p01   = bank_data[{sel_s1.y0_par, sel_s1.x1_par}];
		p10   = bank_data[{sel_s1.y1_par, sel_s1.x0_par}];
		p11   = bank_data[{sel_s1.y1_par, sel_s1.x1_par}];
		fx_s  = $signed({1'b0, sel_s1.fx});
		d_top = $signed({1'b0, p01}) - $signed({1'b0, p00});
		d_bot = $signed({1'b0, p11}) - $signed({1'b0, p10});
		h_top = $signed({2'b00, p00, {FRAC_BITS{1'b0}}}) + d_top * fx_s;
		h_bot = $signed({2'b00, p10, {FRAC_BITS{1'b0}}}) + d_bot * fx_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		h0_s2      <= h_top[LERP_BITS-1:0];
		h1_s2      <= h_bot[LERP_BITS-1:0];
		fy_s2      <= sel_s1.fy;
		clamped_s2 <= sel_s1.clamped;
	end

	// Stage 2: vertical lerp plus half an LSB, then drop fraction bits
	always_comb begin
		fy_s = $signed({1'b0, fy_s2});
		d_v  = $signed({1'b0, h1_s2}) - $signed({1'b0, h0_s2});
		acc  = $signed({2'b00, h0_s2, {FRAC_BITS{1'b0}}}) + d_v * fy_s
			+ $signed(VM_W'(1) << (2 * FRAC_BITS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		value_q   <= acc[ACC_BITS-1:2*FRAC_BITS];
		clamped_q <= clamped_s2;
	end

	assign done         = done_q;
	assign sample_value = value_q;
	assign was_clamped  = clamped_q;

endmodule

`default_nettype wire

[rtl/core/bilinear_image_sampler_unit.sv]
// Top level of the bilinear image sampler: config registers, pixel banks, blend.
// Depends on ibs_pkg, ibs_bank_ram, ibs_addr and ibs_blend.
`default_nettype none

// Takes one request per clock, writes and samples mixed freely; busy never rises.
// A write lands in the pixel store at the edge that accepts it, so a sample in the
// very next cycle already sees it. A sample's result shows on sample_value and
// was_clamped with done high. The accepting edge does the synchronous read of the four
// parity banks (row parity x column parity, so the 2x2 neighbourhood is always one word
// per bank); the two horizontal lerps are registered next, and then the vertical
// lerp with rounding is registered onto the outputs. done is a one-cycle
// strobe and cannot be held off; the sink must take every result as it appears.
// Writes produce no result. Pixels must be written before they are sampled; the
// store has no reset and no clearing pass. Configuration writes are always ready and
// should be issued only while no sample is in flight.
module bilinear_image_sampler_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output      logic                           busy,
	input  wire logic                           action,
	input  wire logic [ibs_pkg::COL_BITS-1:0]    pixel_col,
	input  wire logic [ibs_pkg::ROW_BITS-1:0]    pixel_row,
	input  wire logic [ibs_pkg::PIXEL_BITS-1:0]  pixel_value,
	input  wire logic [ibs_pkg::SAMPLE_BITS-1:0] sample_x,
	input  wire logic [ibs_pkg::SAMPLE_BITS-1:0] sample_y,
	output      logic                           done,
	output      logic [ibs_pkg::PIXEL_BITS-1:0]  sample_value,
	output      logic                           was_clamped,
	input  wire logic                           cfg_valid,
	output      logic                           cfg_ready,
	input  wire logic                           cfg_index,
	input  wire logic [ibs_pkg::DIM_BITS-1:0]    cfg_data
);
	import ibs_pkg::*;

	logic                                    accept;
	logic                                    sample_req;
	logic                                    write_req;
	logic [DIM_BITS-1:0]                     image_cols_q, image_rows_q;
	logic [DIM_BITS-1:0]                     cols_use, rows_use;
	logic [NUM_BANKS-1:0][BANK_AW-1:0]       rd_addr;
	logic [NUM_BANKS-1:0][PIXEL_BITS-1:0]    bank_data;
	logic [BANK_SEL_W-1:0]                   wr_bank;
	logic [BANK_AW-1:0]                      wr_addr;
	ibs_sel_t                                sel;
	ibs_sel_t                                sel_s1;
	logic                                    valid_s1;

	assign busy       = 1'b0;
	assign cfg_ready  = 1'b1;
	assign accept     = start && !busy;
	assign sample_req = accept && (action == ACT_SAMPLE);
	assign write_req  = accept && (action == ACT_WRITE);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_cols_q <= DIM_BITS'(MAX_COLS);
			image_rows_q <= DIM_BITS'(MAX_ROWS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_COLS: image_cols_q <= cfg_data;
				REG_IMAGE_ROWS: image_rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cols_use = dim_in_use(image_cols_q, DIM_BITS'(MAX_COLS));
	assign rows_use = dim_in_use(image_rows_q, DIM_BITS'(MAX_ROWS));

	// Write address: bank by parity, word by the remaining bits
	assign wr_bank = {pixel_row[0], pixel_col[0]};
	assign wr_addr = {pixel_row[ROW_BITS-1:1], pixel_col[COL_BITS-1:1]};

	ibs_addr u_addr (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_req (sample_req),
		.sample_x   (sample_x),
		.sample_y   (sample_y),
		.cols_use   (cols_use),
		.rows_use   (rows_use),
		.rd_addr    (rd_addr),
		.sel        (sel)
	);

	// Pixel store: four parity banks
	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		ibs_bank_ram u_ram (
			.clk     (clk),
			.we      (write_req && (wr_bank == BANK_SEL_W'(b))),
			.wr_addr (wr_addr),
			.wr_data (pixel_value),
			.re      (sample_req),
			.rd_addr (rd_addr[b]),
			.rd_data (bank_data[b])
		);
	end

	// Stage 1 control, aligned with the bank read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= sample_req;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_req) begin
			sel_s1 <= sel;
		end
	end

	ibs_blend u_blend (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.sel_s1       (sel_s1),
		.bank_data    (bank_data),
		.done         (done),
		.sample_value (sample_value),
		.was_clamped  (was_clamped)
	);

`ifndef SYNTH
	// Every sample request yields exactly one result strobe
	ap_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		##3 (done == $past(sample_req, 3)))
		else $error("result strobe does not match sample requests");
	// A pixel write never produces a result
	ap_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		write_req |-> ##3 !done)
		else $error("result strobe after a pixel write");
`endif

endmodule

`default_nettype wire
